### rtl/itoa_pkg.sv
// ============================================================================
// itoa_pkg
// Shared types, codes and the helper function of the integer to ASCII formatter.
// ============================================================================
`default_nettype none

package itoa_pkg;

    // Format selector codes carried on the operation field.
    typedef enum logic [1:0] {
        OP_SDEC = 2'd0,
        OP_UDEC = 2'd1,
        OP_LHEX = 2'd2,
        OP_UHEX = 2'd3
    } op_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_FIND,
        ST_SIGN,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the input transaction
        logic step;        // one shift-and-add-3 conversion step
        logic find;        // latch the index of the leading digit
        logic emit_sign;   // put a minus sign into the output register
        logic emit_digit;  // put the current digit into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hex;         // hexadecimal format, no conversion needed
        logic neg;         // signed value below zero
        logic conv_last;   // the current step is the final one
        logic out_free;    // output register can take a character this cycle
        logic idx_zero;    // the current digit is the least significant one
    } status_t;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_LOWER = 8'h61;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // ASCII code of one digit; letters above nine.
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] d8;
        d8 = {4'd0, d};
        if (d < 4'd10) begin
            return CHAR_ZERO + d8;
        end
        return (upper ? CHAR_UPPER : CHAR_LOWER) + d8 - 8'd10;
    endfunction

endpackage

`default_nettype wire

### rtl/integer_to_ascii_formatter.sv
// ============================================================================
// integer_to_ascii_formatter
// Formats one word as signed or unsigned decimal or as lower or upper hex.
// ============================================================================
// Usage: the input channel (s_valid, s_ready, s_value, s_operation) takes one
// word per transaction together with its format. The result channel (m_valid,
// m_ready, m_character, m_last) returns the ASCII text one character per
// transaction, most significant digit first, with m_last on the final one.
// A negative signed value is preceded by a minus sign; zero gives one '0'.
// Timing: the block works on one word at a time. Decimal formats run a
// shift-and-add-3 binary to BCD conversion of one bit per cycle. After a
// word is accepted come the conversion, the leading digit search and then
// the characters including the sign, one per cycle while the receiver takes
// them. Hex formats skip the conversion. Each character is registered in the
// output register before it appears on m_character.
// Reset (aresetn low, synchronous) returns the controller to idle and empties
// the output register. When the receiver stalls, the character waits in the
// output register and the controller holds until it is taken. s_ready is high
// only while the block is idle, which may overlap a last character waiting.
// ============================================================================
`default_nettype none

module integer_to_ascii_formatter
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [VALUE_WIDTH-1:0] s_value,
    input  wire logic [1:0]             s_operation,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [7:0]                  m_character,
    output logic                        m_last
);

    // Commands flow from the controller to the datapath, status flows back.
    cmd_t    cmd;
    status_t sts;

    itoa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    itoa_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_value     (s_value),
        .s_operation (s_operation),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    // A word in work blocks the next one until its last character is issued.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a word is being formatted");

    // A minus sign always has digits after it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_character == CHAR_MINUS) |-> !m_last)
        else $error("minus sign marked as final character");

    // Every character is a digit, a letter of the hex range or a minus sign.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_character >= 8'h30) && (m_character <= 8'h39)) ||
                    ((m_character >= 8'h61) && (m_character <= 8'h66)) ||
                    ((m_character >= 8'h41) && (m_character <= 8'h46)) ||
                    (m_character == CHAR_MINUS))
        else $error("character outside the formatter alphabet");

endmodule

`default_nettype wire

### rtl/itoa_ctrl.sv
// ============================================================================
// itoa_ctrl
// Controller state machine: sequences conversion, digit search and output.
// ============================================================================
`default_nettype none

module itoa_ctrl
    import itoa_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire status_t sts,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (sts.hex || sts.conv_last) begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND: begin
                state_next = sts.neg ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN: begin
                if (sts.out_free) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free && sts.idx_zero) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd            = '0;
        s_ready        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_CONV: begin
                cmd.step = !sts.hex;
            end
            ST_FIND: begin
                cmd.find = 1'b1;
            end
            ST_SIGN: begin
                cmd.emit_sign = sts.out_free;
            end
            ST_EMIT: begin
                cmd.emit_digit = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/itoa_datapath.sv
// ============================================================================
// itoa_datapath
// Digit register, binary to BCD shifter, leading digit search, output register.
// ============================================================================
`default_nettype none

module itoa_datapath
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [VALUE_WIDTH-1:0] s_value,
    input  wire logic [1:0]             s_operation,
    input  wire cmd_t                   cmd,
    output status_t                     sts,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [7:0]                  m_character,
    output logic                        m_last
);

    localparam int NDEC = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int NHEX = (VALUE_WIDTH + 3) / 4;
    localparam int ND   = (NDEC > NHEX) ? NDEC : NHEX;
    localparam int DW   = 4 * ND;
    localparam int IW   = (ND > 1) ? $clog2(ND) : 1;
    localparam int CW   = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] shift_reg;
    logic [DW-1:0]          digits_reg;
    logic [CW-1:0]          cnt_reg;
    logic [IW-1:0]          idx_reg;
    logic                   neg_reg;
    logic                   upper_reg;
    logic                   hex_reg;
    logic [7:0]             char_reg;
    logic                   last_reg;
    logic                   mvalid_reg;

    logic [VALUE_WIDTH-1:0] mag;
    logic                   in_neg;
    logic [DW-1:0]          load_digits;
    logic [DW-1:0]          adj;
    logic [IW-1:0]          lead;
    logic [3:0]             cur_digit;
    logic                   out_free;

    assign in_neg = (op_t'(s_operation) == OP_SDEC) && s_value[VALUE_WIDTH-1];
    assign mag    = in_neg ? (~s_value + 1'b1) : s_value;

    always_comb begin
        load_digits = '0;
        load_digits[VALUE_WIDTH-1:0] = s_value;
    end

    // Add three to every BCD digit of five or more before the shift.
    always_comb begin
        for (int i = 0; i < ND; i++) begin
            adj[i*4 +: 4] = (digits_reg[i*4 +: 4] >= 4'd5) ?
                            digits_reg[i*4 +: 4] + 4'd3 : digits_reg[i*4 +: 4];
        end
    end

    // Highest nonzero digit; zero gives index zero.
    always_comb begin
        lead = '0;
        for (int i = 0; i < ND; i++) begin
            if (digits_reg[i*4 +: 4] != 4'd0) begin
                lead = IW'(i);
            end
        end
    end

    assign cur_digit = digits_reg[idx_reg*4 +: 4];
    assign out_free  = !mvalid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            shift_reg  <= mag;
            digits_reg <= s_operation[1] ? load_digits : '0;
            cnt_reg    <= CW'(VALUE_WIDTH);
            neg_reg    <= in_neg;
            upper_reg  <= (op_t'(s_operation) == OP_UHEX);
            hex_reg    <= s_operation[1];
        end else if (cmd.step) begin
            shift_reg  <= shift_reg << 1;
            digits_reg <= {adj[DW-2:0], shift_reg[VALUE_WIDTH-1]};
            cnt_reg    <= cnt_reg - 1'b1;
        end
        if (cmd.find) begin
            idx_reg <= lead;
        end else if (cmd.emit_digit) begin
            idx_reg <= idx_reg - 1'b1;
        end
        if (cmd.emit_sign) begin
            char_reg <= CHAR_MINUS;
            last_reg <= 1'b0;
        end else if (cmd.emit_digit) begin
            char_reg <= digit_char(cur_digit, upper_reg);
            last_reg <= (idx_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (cmd.emit_sign || cmd.emit_digit) begin
            mvalid_reg <= 1'b1;
        end else if (m_ready) begin
            mvalid_reg <= 1'b0;
        end
    end

    assign sts.hex       = hex_reg;
    assign sts.neg       = neg_reg;
    assign sts.conv_last = (cnt_reg == CW'(1));
    assign sts.out_free  = out_free;
    assign sts.idx_zero  = (idx_reg == '0);

    assign m_valid     = mvalid_reg;
    assign m_character = char_reg;
    assign m_last      = last_reg;

endmodule

`default_nettype wire

### tb/tb_top.sv
// ============================================================================
// tb_top
// Self-checking testbench of the integer to ASCII formatter.
// ============================================================================
// Words are queued with a format by the stimulus process. A clocked driver
// presents them on the input channel. At each accepted input transaction an
// independent formatter model appends the expected characters to a queue. A
// clocked monitor compares every accepted output transaction with the oldest
// expected character, field by field. Both sides insert random idle bursts.
// The receiver also holds off once for a long stretch so that the block
// stalls its input. A watchdog ends the run if traffic stops.
// ============================================================================
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import itoa_pkg::*;

    // The receiver's single long hold-off, in cycles.
    localparam int RX_HOLD_CYCLES = 400;
    // Cycles without any accepted transaction before the run is declared hung.
    // The longest quiet stretch in a correct run is the hold-off above.
    localparam int WATCHDOG_LIMIT = 3000;
    // Quiet cycles allowed after the last expected character, to catch extras.
    localparam int TAIL_CYCLES = 64;

    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_MINUS   = 8'h2D;

    // One formatting request waiting for the driver.
    typedef struct packed {
        logic [31:0] value;
        op_t         fmt;
    } word_req_t;

    // One expected output character.
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } glyph_t;

    // Clock and reset.
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // Input channel, driven at the falling edge.
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [31:0] s_value     = '0;
    logic [1:0]  s_operation = '0;

    // Output channel; m_ready is driven at the falling edge.
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_character;
    logic       m_last;

    // Words queued by the stimulus process and not yet presented.
    word_req_t words_to_send[$];
    word_req_t next_word;
    int        words_queued = 0;
    int        words_taken  = 0;

    // Characters that the formatter model predicts, oldest first.
    glyph_t expected_text[$];
    glyph_t want;

    // Set at a rising edge when the input transaction on the bus was taken.
    logic in_taken = 1'b0;

    // Idle-burst control for each side.
    logic sender_gaps_on   = 1'b0;
    logic receiver_gaps_on = 1'b0;
    int   send_gap         = 0;
    int   recv_gap         = 0;

    // Long hold-off request from the stimulus process and the receiver's
    // acknowledge; the receiver counts the hold-off itself.
    logic rx_hold_req  = 1'b0;
    logic rx_hold_ack  = 1'b0;
    int   rx_hold_left = 0;

    int mismatch_count = 0;
    int stall_cycles   = 0;

    always begin
        #5 aclk = ~aclk;
    end

    integer_to_ascii_formatter u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    // ------------------------------------------------------------------------
    // Formatter model. Appends the text of one word to expected_text: an
    // optional minus sign in signed mode, then the digits, most significant
    // first, with the last flag on the final character. The magnitude of a
    // negative value is formed in unsigned arithmetic, so the most negative
    // word comes out in full.
    // ------------------------------------------------------------------------
    function automatic void format_word(input logic [31:0] word, input op_t fmt);
        logic [31:0] magnitude;
        logic [31:0] radix;
        logic [31:0] digit;
        logic [7:0]  digits[$];
        glyph_t      g;
        magnitude = word;
        radix = (fmt == OP_LHEX || fmt == OP_UHEX) ? 32'd16 : 32'd10;
        if (fmt == OP_SDEC && word[31]) begin
            magnitude = ~word + 32'd1;
            g.code = ASCII_MINUS;
            g.last = 1'b0;
            expected_text.push_back(g);
        end
        do begin
            digit = magnitude % radix;
            if (digit < 32'd10) begin
                digits.push_front(ASCII_ZERO + digit[7:0]);
            end else if (fmt == OP_UHEX) begin
                digits.push_front(ASCII_UPPER_A + digit[7:0] - 8'd10);
            end else begin
                digits.push_front(ASCII_LOWER_A + digit[7:0] - 8'd10);
            end
            magnitude = magnitude / radix;
        end while (magnitude != 32'd0);
        foreach (digits[i]) begin
            g.code = digits[i];
            g.last = (i == digits.size() - 1);
            expected_text.push_back(g);
        end
    endfunction

    // Queues one word for the driver. Called only right after a rising edge.
    task automatic queue_word(input logic [31:0] value, input op_t fmt);
        word_req_t req;
        req.value = value;
        req.fmt   = fmt;
        words_to_send.push_back(req);
        words_queued++;
    endtask

    // Random word, biased toward the interesting corners: short numbers,
    // values near zero from both sides, powers of ten and their neighbors,
    // and the region around the most negative signed value.
    function automatic logic [31:0] pick_value();
        logic [31:0] p;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom >> $urandom_range(0, 31);
            2: return $urandom_range(0, 20);
            3: return 32'hFFFF_FFFF - $urandom_range(0, 20);
            4: begin
                p = 32'd1;
                repeat ($urandom_range(0, 9)) p = p * 32'd10;
                return p + $urandom_range(0, 2) - 32'd1;
            end
            default: return 32'h8000_0000 + $urandom_range(0, 4) - 32'd2;
        endcase
    endfunction

    // Waits until every queued word was taken and every expected character
    // has come back, then realigns to a rising edge. Queue and counters are
    // only changed at rising edges, so they are looked at on falling edges.
    task automatic wait_drained();
        do @(negedge aclk);
        while (words_taken != words_queued || expected_text.size() != 0);
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Driver. A presented word stays on the bus until in_taken shows that it
    // was accepted. Between words the driver may start a random idle burst
    // while sender gaps are enabled.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            // Keep offering the same transaction.
        end else if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            s_valid  <= 1'b0;
        end else if (sender_gaps_on && $urandom_range(0, 5) == 0) begin
            send_gap <= $urandom_range(0, 18);
            s_valid  <= 1'b0;
        end else if (words_to_send.size() != 0) begin
            next_word   = words_to_send.pop_front();
            s_valid     <= 1'b1;
            s_value     <= next_word.value;
            s_operation <= next_word.fmt;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. The long hold-off takes priority; otherwise it idles in
    // random bursts while receiver gaps are enabled.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (rx_hold_req && !rx_hold_ack) begin
            rx_hold_ack  <= 1'b1;
            rx_hold_left <= RX_HOLD_CYCLES - 1;
            m_ready      <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_ready      <= 1'b0;
        end else if (recv_gap != 0) begin
            recv_gap <= recv_gap - 1;
            m_ready  <= 1'b0;
        end else if (receiver_gaps_on && $urandom_range(0, 5) == 0) begin
            recv_gap <= $urandom_range(0, 18);
            m_ready  <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Input monitor. Each accepted input transaction is run through the
    // formatter model right away, so its characters are queued long before
    // the block can emit the first of them.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            format_word(s_value, op_t'(s_operation));
            words_taken <= words_taken + 1;
            in_taken    <= 1'b1;
        end else begin
            in_taken <= 1'b0;
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] expected_val,
                                   input logic [7:0] actual_val);
        mismatch_count++;
        $display("%0t ns: %s mismatch, expected %h, actual %h",
                 $realtime, what, expected_val, actual_val);
    endtask

    // ------------------------------------------------------------------------
    // Output monitor and watchdog. Every accepted output transaction is
    // checked against the oldest expected character; a character with
    // nothing waiting is a failure too. The watchdog counts cycles in which
    // neither channel completes a transaction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_text.size() == 0) begin
                report_mismatch("unexpected character", 8'h00, m_character);
            end else begin
                want = expected_text.pop_front();
                if (m_character !== want.code) begin
                    report_mismatch("character", want.code, m_character);
                end
                if (m_last !== want.last) begin
                    report_mismatch("last flag", {7'd0, want.last}, {7'd0, m_last});
                end
            end
        end

        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------------
    initial begin
        // Reset is held low at the start and then released for good.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: zero in every format, single digits and digit-count
        // boundaries, the signed extremes including the most negative value,
        // all ones in every format, and hex words with both letter cases.
        sender_gaps_on   = 1'b1;
        receiver_gaps_on = 1'b1;
        queue_word(32'd0,          OP_SDEC);
        queue_word(32'd0,          OP_UDEC);
        queue_word(32'd0,          OP_LHEX);
        queue_word(32'd0,          OP_UHEX);
        queue_word(32'd1,          OP_SDEC);
        queue_word(32'd9,          OP_UDEC);
        queue_word(32'd10,         OP_UDEC);
        queue_word(32'd15,         OP_LHEX);
        queue_word(32'd16,         OP_UHEX);
        queue_word(32'h7FFF_FFFF,  OP_SDEC);
        queue_word(32'h8000_0000,  OP_SDEC);
        queue_word(32'h8000_0000,  OP_UDEC);
        queue_word(32'hFFFF_FFFF,  OP_SDEC);
        queue_word(32'hFFFF_FFFF,  OP_UDEC);
        queue_word(32'hFFFF_FFFF,  OP_LHEX);
        queue_word(32'hFFFF_FFFF,  OP_UHEX);
        queue_word(32'hDEAD_BEEF,  OP_LHEX);
        queue_word(32'hDEAD_BEEF,  OP_UHEX);
        queue_word(32'd1000000000, OP_UDEC);
        queue_word(32'd999999999,  OP_UDEC);
        queue_word(32'hFFFF_FFF6,  OP_SDEC);
        queue_word(32'h0ABC_DEF0,  OP_UHEX);
        queue_word(32'h0000_000A,  OP_LHEX);

        // The sender pauses here until every expected character has come.
        wait_drained();

        // Back-pressure: the sender keeps offering words while the receiver
        // holds off, so the output register fills and s_ready drops.
        sender_gaps_on   = 1'b0;
        receiver_gaps_on = 1'b0;
        repeat (20) queue_word(pick_value(), op_t'($urandom_range(0, 3)));
        rx_hold_req = 1'b1;
        while (!rx_hold_ack) @(posedge aclk);
        rx_hold_req = 1'b0;
        wait_drained();

        // Random part in chunks. Each chunk picks whether either side idles,
        // so there are stretches with gaps on one side, both, or neither.
        for (int chunk = 0; chunk < 8; chunk++) begin
            sender_gaps_on   = ($urandom_range(0, 3) != 0);
            receiver_gaps_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 40; n++) begin
                while (words_to_send.size() > 2) @(posedge aclk);
                queue_word(pick_value(), op_t'($urandom_range(0, 3)));
            end
        end

        // Final stretch at full rate on both sides.
        while (words_to_send.size() != 0) @(posedge aclk);
        sender_gaps_on   = 1'b0;
        receiver_gaps_on = 1'b0;
        repeat (60) queue_word(pick_value(), op_t'($urandom_range(0, 3)));

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (mismatch_count == 0 && expected_text.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
